// ----- src/tt_pkg.sv -----
package tt_pkg;

   localparam int TABLE_ENTRIES = 65536;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int KEY_W         = 64;
   localparam int TAG_W         = KEY_W - IDX_W;
   localparam int PAYLOAD_W     = 44;
   localparam int ENTRY_W       = 1 + TAG_W + PAYLOAD_W;
   localparam int REQ_TDATA_W   = 112;
   localparam int REQ_TUSER_W   = 1;
   localparam int RSP_TDATA_W   = 48;
   localparam int RSP_TUSER_W   = 2;

   localparam logic OP_PROBE = 1'b0;
   localparam logic OP_STORE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   typedef struct packed {
      logic [6:0]  move_to;
      logic [6:0]  move_from;
      logic [1:0]  bound;
      logic [21:0] score;
      logic [5:0]  depth;
   } payload_type;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      payload_type      payload;
   } entry_type;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
      payload_type      payload;
   } req_type;

   typedef struct packed {
      logic        wr_en;
      entry_type   wr_entry;
      logic        hit;
      logic        stored;
      payload_type found;
   } dec_type;

endpackage

// ----- src/tt_ram.sv -----
module tt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tt_match.sv -----
module tt_match (
   input  tt_pkg::req_type   req,
   input  tt_pkg::entry_type entry,
   output tt_pkg::dec_type   dec
);

   logic tag_eq;
   logic blocked;

   always_comb begin
      tag_eq  = (entry.tag == req.key[tt_pkg::KEY_W-1:tt_pkg::IDX_W]);
      blocked = entry.valid && (entry.payload.depth > req.payload.depth);

      dec.hit    = (req.op == tt_pkg::OP_PROBE) && entry.valid && tag_eq;
      dec.stored = (req.op == tt_pkg::OP_STORE) && !blocked;
      dec.found  = dec.hit ? entry.payload : '0;

      dec.wr_en            = dec.stored;
      dec.wr_entry.valid   = 1'b1;
      dec.wr_entry.tag     = req.key[tt_pkg::KEY_W-1:tt_pkg::IDX_W];
      dec.wr_entry.payload = req.payload;
   end

endmodule

// ----- src/transposition_table.sv -----
// Channel  Direction  tvalid/tready         Contents
// req      in         req_tvalid/tready     op in tuser; key and entry fields in tdata
// rsp      out        rsp_tvalid/tready     hit, stored in tuser; found entry in tdata
//
// One item at a time: the slot is read in the accept cycle; the result is
// formed and written back once the output is free, on the single table RAM.
// After reset a clearing pass writes every slot (TABLE_ENTRIES, 65536),
// with req_tready low.
// A result held by rsp_tready low stalls the next write-back only; a new
// beat is still taken while the previous result waits.
module transposition_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // key[63:0], depth[69:64], score[91:70], bound[93:92], move_from[100:94],
   // move_to[107:101], zero[111:108]
   input  logic [tt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op[0]
   input  logic [tt_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // found_depth[5:0], found_score[27:6], found_bound[29:28], found_from[36:30],
   // found_to[43:37], zero[47:44]
   output logic [tt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // hit[0], stored[1]
   output logic [tt_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   tt_pkg::state_type               state_ff, state_in;
   logic [tt_pkg::IDX_W-1:0]        clr_cnt_ff, clr_cnt_in;
   tt_pkg::req_type                 req_ff, req_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tt_pkg::RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [tt_pkg::RSP_TUSER_W-1:0]  rsp_tuser_ff, rsp_tuser_in;

   logic                            accept;
   logic                            out_free;
   logic                            finish;
   logic                            wr_en;
   logic [tt_pkg::IDX_W-1:0]        wr_addr;
   tt_pkg::entry_type               wr_entry;
   logic [tt_pkg::ENTRY_W-1:0]      rd_data;
   tt_pkg::entry_type               rd_entry;
   tt_pkg::dec_type                 dec;

   assign req_tready = (state_ff == tt_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish     = (state_ff == tt_pkg::ST_LOOK) && out_free;
   assign rd_entry   = tt_pkg::entry_type'(rd_data);

   tt_ram #(
      .WIDTH(tt_pkg::ENTRY_W),
      .DEPTH(tt_pkg::TABLE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (accept),
      .rd_addr(req_tdata[tt_pkg::IDX_W-1:0]),
      .rd_data(rd_data)
   );

   tt_match u_match (
      .req  (req_ff),
      .entry(rd_entry),
      .dec  (dec)
   );

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      wr_en      = 1'b0;
      wr_addr    = req_ff.key[tt_pkg::IDX_W-1:0];
      wr_entry   = dec.wr_entry;
      case (state_ff)
         tt_pkg::ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_entry   = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = tt_pkg::ST_IDLE;
            end
         end
         tt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tt_pkg::ST_LOOK;
            end
         end
         tt_pkg::ST_LOOK: begin
            if (out_free) begin
               wr_en    = dec.wr_en;
               state_in = tt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tt_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      if (accept) begin
         req_in.op      = req_tuser[0];
         req_in.key     = req_tdata[tt_pkg::KEY_W-1:0];
         req_in.payload = req_tdata[tt_pkg::KEY_W+tt_pkg::PAYLOAD_W-1:tt_pkg::KEY_W];
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_tdata_in = {{(tt_pkg::RSP_TDATA_W-tt_pkg::PAYLOAD_W){1'b0}}, dec.found};
         rsp_tuser_in = {dec.stored, dec.hit};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tt_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ----- src/tt_checker.sv -----
module tt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [tt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [tt_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [tt_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat shown right after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request beat taken while one is in flight");

   a_hit_or_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result beat flags both hit and stored");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("result beat without hit carries entry data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind transposition_table tt_checker u_tt_checker (.*);

// ----- verif/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_LOWER = 2'd1;
   localparam logic [1:0] BOUND_UPPER = 2'd2;
   localparam logic [1:0] BOUND_CODE3 = 2'd3;

   localparam int RANDOM_ITEMS = 852;
   localparam int KEY_POOL     = 16;
   localparam int SLOT_POOL    = 6;
   localparam int STALL_CYCLES = 400;
   localparam int DIRECTED_N   = 20;

   typedef struct packed {
      logic                hit;
      logic                stored;
      tt_pkg::payload_type found;
   } result_type;

   typedef struct {
      logic        op;
      logic [63:0] key;
      logic [5:0]  depth;
      logic [21:0] score;
      logic [1:0]  bound;
      logic [6:0]  from_sq;
      logic [6:0]  to_sq;
      bit          fixed;
      logic        hit;
      logic        stored;
   } access_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tt_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [tt_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [tt_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [tt_pkg::RSP_TUSER_W-1:0] rsp_tuser;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   bit stall_request = 1'b0;
   bit hold_off      = 1'b0;

   bit                  mirror_valid   [tt_pkg::TABLE_ENTRIES];
   logic [63:0]         mirror_key     [tt_pkg::TABLE_ENTRIES];
   tt_pkg::payload_type mirror_payload [tt_pkg::TABLE_ENTRIES];

   result_type  pending_results [$];
   logic [63:0] key_pool [KEY_POOL];
   logic [15:0] slot_pool [SLOT_POOL];

   // fixed rows are misses or stores, so every found field is zero there
   access_row_type access_rows [DIRECTED_N] = '{
      '{tt_pkg::OP_PROBE, 64'h0123_4567_89AB_CDEF, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b1, 1'b0, 1'b0},
      '{tt_pkg::OP_PROBE, 64'h0, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b1, 1'b0, 1'b0},
      '{tt_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 22'h3FFFFF, BOUND_CODE3, 7'd127,
        7'd127, 1'b1, 1'b0, 1'b0},
      '{tt_pkg::OP_STORE, 64'h0123_4567_89AB_CDEF, 6'd10, 22'h1E8480, BOUND_EXACT, 7'd0,
        7'd89, 1'b1, 1'b0, 1'b1},
      '{tt_pkg::OP_PROBE, 64'h0123_4567_89AB_CDEF, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_PROBE, 64'hFEDC_BA98_7654_CDEF, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_STORE, 64'hFEDC_BA98_7654_CDEF, 6'd9, 22'd5, BOUND_LOWER, 7'd10, 7'd20,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_STORE, 64'hFEDC_BA98_7654_CDEF, 6'd10, 22'h3FFFFF, BOUND_UPPER, 7'd45,
        7'd46, 1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_PROBE, 64'h0123_4567_89AB_CDEF, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_PROBE, 64'hFEDC_BA98_7654_CDEF, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 22'h217B80, BOUND_UPPER, 7'd89,
        7'd0, 1'b1, 1'b0, 1'b1},
      '{tt_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 22'd1, BOUND_LOWER, 7'd1, 7'd2,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_STORE, 64'h0, 6'd0, 22'h1FFFFF, BOUND_CODE3, 7'd127, 7'd127,
        1'b1, 1'b0, 1'b1},
      '{tt_pkg::OP_PROBE, 64'h0, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_STORE, 64'h8000_0000_0000_0000, 6'd0, 22'h200000, BOUND_LOWER, 7'd90,
        7'd100, 1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_PROBE, 64'h0, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_PROBE, 64'h8000_0000_0000_0000, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0},
      '{tt_pkg::OP_STORE, 64'h5555_AAAA_3C3C_0F0F, 6'd32, 22'h2AAAAA, BOUND_EXACT, 7'd85,
        7'd3, 1'b1, 1'b0, 1'b1},
      '{tt_pkg::OP_PROBE, 64'h5555_AAAA_3C3C_0F0F, 6'd0, 22'd0, BOUND_EXACT, 7'd0, 7'd0,
        1'b0, 1'b0, 1'b0}
   };

   transposition_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic result_type probe_or_store(tt_pkg::req_type r);
      result_type  res;
      logic [15:0] slot;
      res  = '0;
      slot = r.key[tt_pkg::IDX_W-1:0];
      if (r.op == tt_pkg::OP_PROBE) begin
         if (mirror_valid[slot] && mirror_key[slot] == r.key) begin
            res.hit   = 1'b1;
            res.found = mirror_payload[slot];
         end
      end else if (!(mirror_valid[slot] && mirror_payload[slot].depth > r.payload.depth)) begin
         mirror_valid[slot]   = 1'b1;
         mirror_key[slot]     = r.key;
         mirror_payload[slot] = r.payload;
         res.stored           = 1'b1;
      end
      return res;
   endfunction

   function automatic tt_pkg::req_type random_access();
      tt_pkg::req_type r;
      int              span;
      r.op = ($urandom_range(0, 1) != 0) ? tt_pkg::OP_STORE : tt_pkg::OP_PROBE;
      if ($urandom_range(0, 99) < 70)
         r.key = key_pool[$urandom_range(0, KEY_POOL-1)];
      else
         r.key = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       r.payload.depth = 6'd0;
         1:       r.payload.depth = 6'd63;
         default: r.payload.depth = 6'($urandom_range(0, 63));
      endcase
      if ($urandom_range(0, 99) < 75) begin
         span            = $urandom_range(0, 4000000);
         r.payload.score = 22'(span - 2000000);
      end else begin
         r.payload.score = 22'($urandom);
      end
      r.payload.bound = ($urandom_range(0, 9) == 0) ? BOUND_CODE3 : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) begin
         r.payload.move_from = 7'($urandom_range(0, 127));
         r.payload.move_to   = 7'($urandom_range(0, 127));
      end else begin
         r.payload.move_from = 7'($urandom_range(0, 89));
         r.payload.move_to   = 7'($urandom_range(0, 89));
      end
      return r;
   endfunction

   function automatic string describe(result_type r);
      return $sformatf("hit=%0b stored=%0b depth=%0d score=%0d bound=%0d from=%0d to=%0d",
                       r.hit, r.stored, r.found.depth, $signed(r.found.score),
                       r.found.bound, r.found.move_from, r.found.move_to);
   endfunction

   task automatic send_access(tt_pkg::req_type r, bit fixed, result_type typed);
      result_type want;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, r.payload, r.key};
      req_tuser  <= r.op;
      do @(posedge clock); while (!req_tready);
      want = probe_or_store(r);
      if (fixed)
         want = typed;
      pending_results = {pending_results, want};
   endtask

   task automatic check_result(result_type got);
      result_type want;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected beat: %s", describe(got));
      end else begin
         want = pending_results.pop_front();
         if (got.hit !== want.hit || got.stored !== want.stored ||
             got.found.depth !== want.found.depth || got.found.score !== want.found.score ||
             got.found.bound !== want.found.bound ||
             got.found.move_from !== want.found.move_from ||
             got.found.move_to !== want.found.move_to) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch expected %s", describe(want));
               $display("         actual   %s", describe(got));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_result({rsp_tuser[0], rsp_tuser[1],
                          tt_pkg::payload_type'(rsp_tdata[tt_pkg::PAYLOAD_W-1:0])});
         rsp_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      wait (stall_request);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      tt_pkg::req_type item;
      result_type      typed;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (slot_pool[i])
         slot_pool[i] = 16'($urandom);
      foreach (key_pool[i]) begin
         key_pool[i]        = {$urandom, $urandom};
         key_pool[i][15:0]  = slot_pool[i % SLOT_POOL];
      end
      foreach (access_rows[i]) begin
         item.op                = access_rows[i].op;
         item.key               = access_rows[i].key;
         item.payload.depth     = access_rows[i].depth;
         item.payload.score     = access_rows[i].score;
         item.payload.bound     = access_rows[i].bound;
         item.payload.move_from = access_rows[i].from_sq;
         item.payload.move_to   = access_rows[i].to_sq;
         typed                  = '0;
         typed.hit              = access_rows[i].hit;
         typed.stored           = access_rows[i].stored;
         send_access(item, access_rows[i].fixed, typed);
      end
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 68 : 0;
         recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 8 : 0;
         if (phase == 2)
            stall_request = 1'b1;
         repeat (RANDOM_ITEMS / 3)
            send_access(random_access(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
src/tt_pkg.sv
src/tt_ram.sv
src/tt_match.sv
src/transposition_table.sv
src/tt_checker.sv
verif/tb_top.sv
